// ===== hw/rtl/line_pixel_generator_assert.svh =====
// Assertion helpers shared by the line pixel generator RTL.
`ifndef LINE_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LPG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lpg_pkg.sv =====
package lpg_pkg;

    // Input word opcode
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // RGB565 color width
    localparam int COLOR_BITS = 16;

    // Extra bits of the signed error term beyond the coordinate width
    localparam int ERR_EXTRA_BITS = 4;

endpackage

// ===== hw/rtl/lpg_stepper.sv =====
`include "line_pixel_generator_assert.svh"

module lpg_stepper #(
    parameter int COORD_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // one input word is consumed when step_en is high
    input  logic                           step_en,
    input  lpg_pkg::op_t                   op,
    input  logic [COORD_BITS-1:0]          x_start,
    input  logic [COORD_BITS-1:0]          y_start,
    input  logic [COORD_BITS-1:0]          x_end,
    input  logic [COORD_BITS-1:0]          y_end,
    input  logic [lpg_pkg::COLOR_BITS-1:0] color,
    // result of the word presented now
    output logic [COORD_BITS-1:0]          res_x,
    output logic [COORD_BITS-1:0]          res_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] res_color,
    output logic                           res_valid,
    output logic                           res_last
);

    localparam int ErrBits = COORD_BITS + lpg_pkg::ERR_EXTRA_BITS;
    localparam logic [COORD_BITS-1:0] CoordOne = COORD_BITS'(1);

    // Line state
    logic [COORD_BITS-1:0]          cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]          cur_y_reg, cur_y_next;
    logic signed [ErrBits-1:0]      err_reg, err_next;
    logic [COORD_BITS-1:0]          abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0]          abs_dy_reg, abs_dy_next;
    logic                           neg_x_reg, neg_x_next;
    logic                           neg_y_reg, neg_y_next;
    logic                           steep_reg, steep_next;
    logic [COORD_BITS-1:0]          rem_reg, rem_next;
    logic [lpg_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic                           busy_reg, busy_next;

    // Start-of-line setup terms
    logic                      s_neg_x, s_neg_y, s_steep;
    logic [COORD_BITS-1:0]     s_adx, s_ady, s_major, s_minor;
    logic signed [ErrBits-1:0] s_err;

    // Step terms
    logic [COORD_BITS-1:0]     t_major, t_minor, rem_dec;
    logic signed [ErrBits-1:0] t_major2, t_minor2, t_err_adj;
    logic                      t_err_pos;
    logic [COORD_BITS-1:0]     x_move, y_move;

    // Endpoint deltas, step signs and major axis (tie picks x)
    always_comb begin
        s_neg_x = (x_end < x_start);
        s_neg_y = (y_end < y_start);
        s_adx   = s_neg_x ? (x_start - x_end) : (x_end - x_start);
        s_ady   = s_neg_y ? (y_start - y_end) : (y_end - y_start);
        s_steep = (s_adx < s_ady);
        s_major = s_steep ? s_ady : s_adx;
        s_minor = s_steep ? s_adx : s_ady;
        s_err   = $signed({3'b000, s_minor, 1'b0}) - $signed({4'b0000, s_major});
    end

    // One Bresenham step from the stored state
    always_comb begin
        t_major   = steep_reg ? abs_dy_reg : abs_dx_reg;
        t_minor   = steep_reg ? abs_dx_reg : abs_dy_reg;
        t_major2  = $signed({3'b000, t_major, 1'b0});
        t_minor2  = $signed({3'b000, t_minor, 1'b0});
        t_err_pos = (err_reg > 0);
        t_err_adj = t_err_pos ? (err_reg - t_major2) : err_reg;
        x_move    = neg_x_reg ? (cur_x_reg - CoordOne) : (cur_x_reg + CoordOne);
        y_move    = neg_y_reg ? (cur_y_reg - CoordOne) : (cur_y_reg + CoordOne);
        rem_dec   = rem_reg - CoordOne;
    end

    // Next state
    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        steep_next  = steep_reg;
        rem_next    = rem_reg;
        color_next  = color_reg;
        busy_next   = busy_reg;
        if (step_en) begin
            if (op == lpg_pkg::OP_START) begin
                cur_x_next  = x_start;
                cur_y_next  = y_start;
                err_next    = s_err;
                abs_dx_next = s_adx;
                abs_dy_next = s_ady;
                neg_x_next  = s_neg_x;
                neg_y_next  = s_neg_y;
                steep_next  = s_steep;
                rem_next    = s_major;
                color_next  = color;
                busy_next   = (s_major != '0);
            end else if (busy_reg) begin
                // major axis always moves, minor axis when error is positive
                if (steep_reg) begin
                    cur_y_next = y_move;
                    if (t_err_pos) begin
                        cur_x_next = x_move;
                    end
                end else begin
                    cur_x_next = x_move;
                    if (t_err_pos) begin
                        cur_y_next = y_move;
                    end
                end
                err_next  = t_err_adj + t_minor2;
                rem_next  = rem_dec;
                busy_next = (rem_dec != '0);
            end
        end
    end

    // Result of the current word
    always_comb begin
        if (op == lpg_pkg::OP_START) begin
            res_x     = x_start;
            res_y     = y_start;
            res_color = color;
            res_valid = 1'b1;
            res_last  = (s_major == '0);
        end else if (busy_reg) begin
            res_x     = cur_x_next;
            res_y     = cur_y_next;
            res_color = color_reg;
            res_valid = 1'b1;
            res_last  = (rem_dec == '0);
        end else begin
            res_x     = '0;
            res_y     = '0;
            res_color = '0;
            res_valid = 1'b0;
            res_last  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            err_reg    <= '0;
            abs_dx_reg <= '0;
            abs_dy_reg <= '0;
            neg_x_reg  <= 1'b0;
            neg_y_reg  <= 1'b0;
            steep_reg  <= 1'b0;
            rem_reg    <= '0;
            color_reg  <= '0;
            busy_reg   <= 1'b0;
        end else begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            err_reg    <= err_next;
            abs_dx_reg <= abs_dx_next;
            abs_dy_reg <= abs_dy_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            steep_reg  <= steep_next;
            rem_reg    <= rem_next;
            color_reg  <= color_next;
            busy_reg   <= busy_next;
        end
    end

    `LPG_ASSERT_NOW(a_busy_has_steps, aclk, aresetn, busy_reg, rem_reg != '0, "busy with no steps left")
    `LPG_ASSERT_NEXT(a_last_goes_idle, aclk, aresetn, step_en && res_last, !busy_reg, "still busy after last pixel")
    `LPG_ASSERT_NEXT(a_idle_step_holds, aclk, aresetn, step_en && (op == lpg_pkg::OP_STEP) && !busy_reg, $stable(cur_x_reg) && $stable(cur_y_reg) && !busy_reg, "idle step changed position")

endmodule

// ===== hw/rtl/line_pixel_generator.sv =====
// Bresenham line rasterizer, all octants. Every input word gives exactly one
// result word: a start word (op = 0) loads both endpoints and the color and
// returns the first endpoint at once; each step word (op = 1) returns the next
// pixel along the major axis, with last set on the second endpoint, after which
// the block is idle and a step word returns valid_res = 0 with zeroed fields.
// A start word while a line is in progress abandons that line. Throughput is
// one word per clock while the result side keeps m_ready high: a step is a single
// add/compare update of the error term, done combinationally between the input
// register and the result register, which then presents the result on m_valid.
// While a result waits on m_ready the input register takes one more word, then
// s_ready stays low until m_ready.
`include "line_pixel_generator_assert.svh"

module line_pixel_generator #(
    parameter int COORD_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [COORD_BITS-1:0]          s_x_start,
    input  logic [COORD_BITS-1:0]          s_y_start,
    input  logic [COORD_BITS-1:0]          s_x_end,
    input  logic [COORD_BITS-1:0]          s_y_end,
    input  logic [lpg_pkg::COLOR_BITS-1:0] s_color,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [COORD_BITS-1:0]          m_pixel_x,
    output logic [COORD_BITS-1:0]          m_pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] m_pixel_color,
    output logic                           m_valid_res,
    output logic                           m_last
);

    // Input register
    logic                           in_vld_reg, in_vld_next;
    lpg_pkg::op_t                   in_op_reg;
    logic [COORD_BITS-1:0]          in_x0_reg, in_y0_reg, in_x1_reg, in_y1_reg;
    logic [lpg_pkg::COLOR_BITS-1:0] in_color_reg;

    // Result register
    logic                           out_vld_reg, out_vld_next;
    logic [COORD_BITS-1:0]          out_x_reg, out_y_reg;
    logic [lpg_pkg::COLOR_BITS-1:0] out_color_reg;
    logic                           out_res_reg, out_last_reg;

    // Stepper result
    logic [COORD_BITS-1:0]          res_x, res_y;
    logic [lpg_pkg::COLOR_BITS-1:0] res_color;
    logic                           res_valid, res_last;

    logic advance;
    logic s_take;

    // A word moves from input to result register when the result slot frees
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_take) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    lpg_stepper #(
        .COORD_BITS(COORD_BITS)
    ) u_stepper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .op        (in_op_reg),
        .x_start   (in_x0_reg),
        .y_start   (in_y0_reg),
        .x_end     (in_x1_reg),
        .y_end     (in_y1_reg),
        .color     (in_color_reg),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_color (res_color),
        .res_valid (res_valid),
        .res_last  (res_last)
    );

    // Handshake flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_op_reg    <= lpg_pkg::op_t'(s_op);
            in_x0_reg    <= s_x_start;
            in_y0_reg    <= s_y_start;
            in_x1_reg    <= s_x_end;
            in_y1_reg    <= s_y_end;
            in_color_reg <= s_color;
        end
        if (advance) begin
            out_x_reg     <= res_x;
            out_y_reg     <= res_y;
            out_color_reg <= res_color;
            out_res_reg   <= res_valid;
            out_last_reg  <= res_last;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_pixel_x     = out_x_reg;
    assign m_pixel_y     = out_y_reg;
    assign m_pixel_color = out_color_reg;
    assign m_valid_res   = out_res_reg;
    assign m_last        = out_last_reg;

    `LPG_ASSERT_NOW(a_empty_ready, aclk, aresetn, !in_vld_reg, s_ready, "input stage empty but not ready")
    `LPG_ASSERT_NEXT(a_advance_fills, aclk, aresetn, advance, out_vld_reg, "advanced word missing from result")
    `LPG_ASSERT_NEXT(a_stall_keeps, aclk, aresetn, in_vld_reg && out_vld_reg && !m_ready, in_vld_reg && out_vld_reg, "word dropped during stall")

endmodule

// ===== test/line_pixel_generator_test.sv =====
`timescale 1ns / 100ps

module line_pixel_generator_test;

    localparam int COORD_W      = 8;
    localparam int COLOR_W      = lpg_pkg::COLOR_BITS;
    localparam int WORD_TARGET  = 1500;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;

    // One result word as the block should present it
    typedef struct packed {
        bit [COORD_W-1:0]    x;
        bit [COORD_W-1:0]    y;
        bit [COLOR_W-1:0]    color;
        bit                  valid_res;
        bit                  last;
    } pixel_t;

    // Bresenham walk kept alongside the block, plus the queue of pixels still owed
    class raster_scoreboard;
        bit [COORD_W-1:0]    pos_x, pos_y;
        int                  decision;
        bit [COORD_W-1:0]    span_x, span_y;
        bit                  back_x, back_y, y_major;
        bit [COORD_W-1:0]    steps_left;
        bit [COLOR_W-1:0]    ink;
        bit                  drawing;
        pixel_t              expected_pixels[$];
        int                  errors;
        int                  lines, pixels, endpoints, idle_steps;

        // Advance the walk for an accepted input word; returns 1 if it draws
        function bit take_word(lpg_pkg::op_t op, bit [COORD_W-1:0] xs, bit [COORD_W-1:0] ys,
                               bit [COORD_W-1:0] xe, bit [COORD_W-1:0] ye,
                               bit [COLOR_W-1:0] c);
            pixel_t p;
            int     major, minor;
            p = '0;
            if (op == lpg_pkg::OP_START) begin
                back_x   = xe < xs;
                back_y   = ye < ys;
                span_x   = back_x ? xs - xe : xe - xs;
                span_y   = back_y ? ys - ye : ye - ys;
                y_major  = span_x < span_y;
                major    = y_major ? int'(span_y) : int'(span_x);
                minor    = y_major ? int'(span_x) : int'(span_y);
                decision = 2 * minor - major;
                pos_x    = xs;
                pos_y    = ys;
                ink      = c;
                steps_left = COORD_W'(major);
                drawing  = major != 0;
                p = '{pos_x, pos_y, ink, 1'b1, major == 0};
                lines++;
            end else if (drawing) begin
                major = y_major ? int'(span_y) : int'(span_x);
                minor = y_major ? int'(span_x) : int'(span_y);
                // minor axis moves when the decision value is positive
                if (decision > 0) begin
                    if (y_major)
                        pos_x = back_x ? pos_x - 1'b1 : pos_x + 1'b1;
                    else
                        pos_y = back_y ? pos_y - 1'b1 : pos_y + 1'b1;
                    decision -= 2 * major;
                end
                decision += 2 * minor;
                if (y_major)
                    pos_y = back_y ? pos_y - 1'b1 : pos_y + 1'b1;
                else
                    pos_x = back_x ? pos_x - 1'b1 : pos_x + 1'b1;
                steps_left = steps_left - 1'b1;
                if (steps_left == 0)
                    drawing = 1'b0;
                p = '{pos_x, pos_y, ink, 1'b1, steps_left == 0};
            end else begin
                idle_steps++;
            end
            if (p.valid_res)
                pixels++;
            if (p.last)
                endpoints++;
            expected_pixels.push_back(p);
            return p.valid_res;
        endfunction

        // Compare one accepted result word with the oldest pixel owed
        function void check_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COLOR_W-1:0] c, logic v, logic l);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result word x=%0d y=%0d color=%h valid_res=%b last=%b",
                         $time, x, y, c, v, l);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (x !== want.x) begin
                $display("%0t: pixel_x expected %0d, got %0d", $time, want.x, x);
                errors++;
            end
            if (y !== want.y) begin
                $display("%0t: pixel_y expected %0d, got %0d", $time, want.y, y);
                errors++;
            end
            if (c !== want.color) begin
                $display("%0t: pixel_color expected %h, got %h", $time, want.color, c);
                errors++;
            end
            if (v !== want.valid_res) begin
                $display("%0t: valid_res expected %b, got %b", $time, want.valid_res, v);
                errors++;
            end
            if (l !== want.last) begin
                $display("%0t: last expected %b, got %b", $time, want.last, l);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_op;
    logic [COORD_W-1:0]    s_x_start, s_y_start, s_x_end, s_y_end;
    logic [COLOR_W-1:0]    s_color;
    logic                  m_valid;
    logic                  m_ready;
    logic [COORD_W-1:0]    m_pixel_x, m_pixel_y;
    logic [COLOR_W-1:0]    m_pixel_color;
    logic                  m_valid_res;
    logic                  m_last;

    raster_scoreboard sb = new();
    int               drawn_words;
    int               cycle_count;
    bit               calm;
    bit               hold_req;

    line_pixel_generator #(
        .COORD_BITS(COORD_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_x_start     (s_x_start),
        .s_y_start     (s_y_start),
        .s_x_end       (s_x_end),
        .s_y_end       (s_y_end),
        .s_color       (s_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_valid_res   (m_valid_res),
        .m_last        (m_last)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_ready && m_valid !== 1'b0)
            sb.check_pixel(m_pixel_x, m_pixel_y, m_pixel_color, m_valid_res, m_last);
    end

    // Offer one input word, with random idle cycles ahead of it
    task automatic send_word(input lpg_pkg::op_t op, input logic [COORD_W-1:0] xs,
                             input logic [COORD_W-1:0] ys, input logic [COORD_W-1:0] xe,
                             input logic [COORD_W-1:0] ye, input logic [COLOR_W-1:0] c);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_x_start <= xs;
        s_y_start <= ys;
        s_x_end   <= xe;
        s_y_end   <= ye;
        s_color   <= c;
        do
            @(posedge aclk);
        while (!s_ready);
        if (sb.take_word(op, xs, ys, xe, ye, c))
            drawn_words++;
    endtask

    // Step word with junk in the unused fields
    task automatic send_step();
        send_word(lpg_pkg::OP_STEP, COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), COORD_W'($urandom), COLOR_W'($urandom));
    endtask

    task automatic run_line(input int xs, input int ys, input int xe, input int ye,
                            input int c, input int n_steps);
        send_word(lpg_pkg::OP_START, COORD_W'(xs), COORD_W'(ys), COORD_W'(xe),
                  COORD_W'(ye), COLOR_W'(c));
        repeat (n_steps) send_step();
    endtask

    // Stop offering words until the block has returned everything
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // Main sequence
    initial begin
        int  xs, ys, xe, ye, major, n_steps, r;
        bit  hold_done, pause_done;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_op        = lpg_pkg::OP_START;
        s_x_start   = '0;
        s_y_start   = '0;
        s_x_end     = '0;
        s_y_end     = '0;
        s_color     = '0;
        hold_req    = 1'b0;
        calm        = 1'b0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        drawn_words = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: step while idle, single-pixel line, corner-to-corner diagonals,
        // a line abandoned by a new start, and lines in several octants run to the end or past it
        send_step();
        run_line(37, 90, 37, 90, 16'h1234, 1);
        run_line(0, 0, 255, 255, 16'hFFFF, 3);
        run_line(255, 0, 0, 255, 16'h0000, 2);
        run_line(5, 5, 8, 3, 16'hF800, 4);
        run_line(200, 100, 198, 104, 16'h07E0, 4);
        run_line(0, 255, 1, 251, 16'h001F, 4);

        // Random: mostly complete short lines, some long, some cut short or overrun
        while (drawn_words < WORD_TARGET) begin
            if (!hold_done && drawn_words >= 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && drawn_words >= 1000) begin
                wait_drained();
                pause_done = 1'b1;
            end
            calm = drawn_words >= 600 && drawn_words < 850;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_step();
            end else begin
                xs = $urandom_range(0, 255);
                ys = $urandom_range(0, 255);
                if ($urandom_range(0, 99) < 95) begin
                    xe = $urandom_range(xs > 12 ? xs - 12 : 0, xs < 243 ? xs + 12 : 255);
                    ye = $urandom_range(ys > 12 ? ys - 12 : 0, ys < 243 ? ys + 12 : 255);
                end else begin
                    xe = $urandom_range(0, 255);
                    ye = $urandom_range(0, 255);
                end
                major = (xe > xs ? xe - xs : xs - xe);
                if ((ye > ys ? ye - ys : ys - ye) > major)
                    major = ye > ys ? ye - ys : ys - ye;
                r = $urandom_range(0, 99);
                if (r < 15)
                    n_steps = $urandom_range(0, major);
                else if (r < 30)
                    n_steps = major + $urandom_range(1, 2);
                else
                    n_steps = major;
                run_line(xs, ys, xe, ye, $urandom_range(0, 65535), n_steps);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d lines: %0d pixels drawn, %0d endpoints, %0d steps while idle",
                 sb.lines, sb.pixels, sb.endpoints, sb.idle_steps);
        $display("including a %0d-cycle result hold-off and a full drain pause, %0d mismatches",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== line_pixel_generator.f =====
+incdir+hw/rtl
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_stepper.sv
hw/rtl/line_pixel_generator.sv
test/line_pixel_generator_test.sv
